/* hw/rtl/srio_pkg.sv */
// ----------------------------------------------------------------------------
// srio_pkg
// Shared types, codes and small lookup functions of the serial remote I/O link.
// ----------------------------------------------------------------------------
package srio_pkg;

    localparam logic [1:0] KIND_RX    = 2'd0;
    localparam logic [1:0] KIND_SCAN  = 2'd1;
    localparam logic [1:0] KIND_SEND  = 2'd2;

    localparam logic [1:0] RES_LED    = 2'd0;
    localparam logic [1:0] RES_DIGIT  = 2'd1;
    localparam logic [1:0] RES_TX     = 2'd2;

    localparam logic [1:0] TAG_LO     = 2'd0;
    localparam logic [1:0] TAG_MID    = 2'd1;
    localparam logic [1:0] TAG_HI     = 2'd2;
    localparam logic [1:0] TAG_BTN    = 2'd3;

    localparam logic [1:0] BEAT_FIRST = 2'd0;
    localparam logic [1:0] BEAT_LAST  = 2'd3;

    localparam logic [2:0] BLANK_ENTRY = 3'd5;
    localparam logic [7:0] SEG_BLANK   = 8'hff;
    localparam logic [7:0] SEL_FIRST   = 8'h80;

    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] led;
        logic [7:0]  seg;
        logic [7:0]  sel;
    } t_result;

    typedef struct packed {
        logic       hit;
        logic [2:0] idx;
    } t_btn_idx;

    function automatic logic [7:0] seg_code(input logic [2:0] entry);
        logic [7:0] code;
        unique case (entry)
            3'd0:    code = 8'hc6;
            3'd1:    code = 8'hc1;
            3'd2:    code = 8'hc7;
            3'd3:    code = 8'h88;
            3'd4:    code = 8'ha1;
            default: code = SEG_BLANK;
        endcase
        return code;
    endfunction

    function automatic t_btn_idx btn_index(input logic [4:0] btn);
        t_btn_idx r;
        r.hit = 1'b1;
        unique case (btn)
            5'b00001: r.idx = 3'd0;
            5'b00010: r.idx = 3'd1;
            5'b00100: r.idx = 3'd2;
            5'b01000: r.idx = 3'd3;
            5'b10000: r.idx = 3'd4;
            default: begin
                r.hit = 1'b0;
                r.idx = BLANK_ENTRY;
            end
        endcase
        return r;
    endfunction

    function automatic logic [7:0] tx_pack(input logic [1:0] beat,
                                           input logic [15:0] sw,
                                           input logic [4:0] bt);
        logic [7:0] b;
        unique case (beat)
            2'd0:    b = {sw[5:0], TAG_LO};
            2'd1:    b = {1'b0, sw[10:6], TAG_MID};
            2'd2:    b = {1'b0, sw[15:11], TAG_HI};
            default: b = {1'b0, bt, TAG_BTN};
        endcase
        return b;
    endfunction

endpackage

/* hw/rtl/srio_core.sv */
// ----------------------------------------------------------------------------
// srio_core
// Link state: remote switch image, button history ring and scan position.
// Decodes one item per cycle while i_fire is high and forms its first result, if any.
// ----------------------------------------------------------------------------
module srio_core import srio_pkg::*; #(
    parameter int DEPTH = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_fire,
    input  logic [1:0]  i_kind,
    input  logic [7:0]  i_rx_byte,
    output logic        o_has_result,
    output t_result     o_res
);

    localparam int IW = $clog2(DEPTH);
    localparam logic [IW-1:0] LAST_SLOT = IW'(DEPTH - 1);
    localparam logic [3:0] DEPTH_W = 4'(DEPTH);

    logic [15:0]   r_img, n_img;
    logic [4:0]    r_prev_btn, n_prev_btn;
    logic [IW-1:0] r_wr, n_wr;
    logic [2:0]    r_scan, n_scan;
    logic [2:0]    r_hist [DEPTH];

    logic          w_hist_we;
    logic [2:0]    w_hist_val;
    logic [3:0]    w_sum;
    logic [IW-1:0] w_rd;
    logic [4:0]    w_btn;
    t_btn_idx      w_bidx;

    assign w_btn  = i_rx_byte[6:2];
    assign w_bidx = btn_index(w_btn);

    // ring slot shown by the current digit
    always_comb begin
        w_sum = 4'(r_wr) + 4'(r_scan);
        for (int k = 0; k < 8; k++) begin
            if (w_sum >= DEPTH_W) begin
                w_sum = w_sum - DEPTH_W;
            end
        end
        w_rd = w_sum[IW-1:0];
    end

    always_comb begin
        n_img        = r_img;
        n_prev_btn   = r_prev_btn;
        n_wr         = r_wr;
        n_scan       = r_scan;
        w_hist_we    = 1'b0;
        w_hist_val   = w_bidx.idx;
        o_has_result = 1'b0;
        o_res        = '0;
        unique case (i_kind)
            KIND_RX: begin
                unique case (i_rx_byte[1:0])
                    TAG_LO: begin
                        n_img        = {r_img[15:6], i_rx_byte[7:2]};
                        o_has_result = 1'b1;
                    end
                    TAG_MID: begin
                        n_img        = {r_img[15:11], i_rx_byte[6:2], r_img[5:0]};
                        o_has_result = 1'b1;
                    end
                    TAG_HI: begin
                        n_img        = {i_rx_byte[6:2], r_img[10:0]};
                        o_has_result = 1'b1;
                    end
                    default: begin
                        if (w_btn != r_prev_btn) begin
                            n_prev_btn = w_btn;
                            if (w_bidx.hit) begin
                                w_hist_we = 1'b1;
                                n_wr      = (r_wr == LAST_SLOT) ? '0 : r_wr + 1'b1;
                            end
                        end
                    end
                endcase
                o_res.kind = RES_LED;
            end
            KIND_SCAN: begin
                o_has_result = 1'b1;
                o_res.kind   = RES_DIGIT;
                o_res.seg    = seg_code(r_hist[w_rd]);
                o_res.sel    = ~(SEL_FIRST >> r_scan);
                n_scan       = r_scan + 3'd1;
            end
            KIND_SEND: begin
                o_has_result = 1'b1;
                o_res.kind   = RES_TX;
            end
            default: begin
                o_has_result = 1'b0;
            end
        endcase
        o_res.led = n_img;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_img      <= '0;
            r_prev_btn <= '0;
            r_wr       <= '0;
            r_scan     <= '0;
            for (int k = 0; k < DEPTH; k++) begin
                r_hist[k] <= BLANK_ENTRY;
            end
        end else if (i_fire) begin
            r_img      <= n_img;
            r_prev_btn <= n_prev_btn;
            r_wr       <= n_wr;
            r_scan     <= n_scan;
            if (w_hist_we) begin
                r_hist[r_wr] <= w_hist_val;
            end
        end
    end

    a_ring_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_fire && i_kind == KIND_RX && i_rx_byte[1:0] == TAG_BTN
         && w_btn != r_prev_btn && w_bidx.hit) |=> (r_wr != $past(r_wr)))
        else $error("ring write index did not advance on new button");

    a_scan_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_fire && i_kind != KIND_SCAN) |=> (r_scan == $past(r_scan)))
        else $error("scan position moved without a scan tick");

endmodule

/* hw/rtl/srio_out.sv */
// ----------------------------------------------------------------------------
// srio_out
// Result register; a send request is unrolled here into four tagged bytes.
// ----------------------------------------------------------------------------
module srio_out import srio_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_load,
    input  t_result     i_res,
    input  logic [15:0] i_switches,
    input  logic [4:0]  i_buttons,
    input  logic        i_out_ready,
    output logic        o_free,
    output logic        o_out_valid,
    output logic [1:0]  o_result_kind,
    output logic [15:0] o_led_value,
    output logic [7:0]  o_seg_pattern,
    output logic [7:0]  o_digit_select,
    output logic [7:0]  o_tx_byte,
    output logic        o_last
);

    logic        r_valid;
    t_result     r_res;
    logic [7:0]  r_tx;
    logic        r_last;
    logic [1:0]  r_beat, n_beat;
    logic [15:0] r_sw;
    logic [4:0]  r_bt;
    logic        w_take;

    assign w_take = r_valid && i_out_ready;
    assign o_free = !r_valid || (i_out_ready && r_last);
    assign n_beat = r_beat + 2'd1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_last  <= 1'b0;
            r_beat  <= BEAT_FIRST;
        end else if (i_load) begin
            r_valid <= 1'b1;
            r_res   <= i_res;
            r_sw    <= i_switches;
            r_bt    <= i_buttons;
            r_beat  <= BEAT_FIRST;
            if (i_res.kind == RES_TX) begin
                r_tx   <= tx_pack(BEAT_FIRST, i_switches, i_buttons);
                r_last <= 1'b0;
            end else begin
                r_tx   <= '0;
                r_last <= 1'b1;
            end
        end else if (w_take) begin
            if (r_last) begin
                r_valid <= 1'b0;
            end else begin
                r_beat <= n_beat;
                r_tx   <= tx_pack(n_beat, r_sw, r_bt);
                r_last <= (n_beat == BEAT_LAST);
            end
        end
    end

    assign o_out_valid    = r_valid;
    assign o_result_kind  = r_res.kind;
    assign o_led_value    = r_res.led;
    assign o_seg_pattern  = r_res.seg;
    assign o_digit_select = r_res.sel;
    assign o_tx_byte      = r_tx;
    assign o_last         = r_last;

    a_single_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && r_res.kind != RES_TX) |-> r_last)
        else $error("single result not flagged last");

    a_tx_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && r_res.kind == RES_TX) |-> (r_last == (r_beat == BEAT_LAST)))
        else $error("transmit last flag out of step with beat");

endmodule

/* hw/rtl/serial_remote_io_link.sv */
// ----------------------------------------------------------------------------
// serial_remote_io_link
// Byte link endpoint: rebuilds a remote switch image, keeps a button history
// ring for an eight digit display, and packs local levels into tagged bytes.
// ----------------------------------------------------------------------------
// path: an accepted item waits in the input register; its first result word
//   is loaded into the result register when the item advances
// throughput: one item per cycle for bytes and scan ticks unless stalled;
//   a send holds the result register for four bytes, one per ready cycle
// reset: synchronous, clears image, button, indices and handshake state;
//   the history ring is set to blank at once, no clearing pass
module serial_remote_io_link import srio_pkg::*; #(
    parameter int HISTORY_DEPTH = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_kind,
    input  logic [7:0]  i_rx_byte,
    input  logic [15:0] i_switches,
    input  logic [4:0]  i_buttons,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [1:0]  o_result_kind,
    output logic [15:0] o_led_value,
    output logic [7:0]  o_seg_pattern,
    output logic [7:0]  o_digit_select,
    output logic [7:0]  o_tx_byte,
    output logic        o_last
);

    logic        r_in_valid;
    logic [1:0]  r_kind;
    logic [7:0]  r_rx;
    logic [15:0] r_sw;
    logic [4:0]  r_bt;

    logic        w_advance;
    logic        w_has_result;
    logic        w_out_free;
    t_result     w_res;

    assign w_advance  = r_in_valid && (!w_has_result || w_out_free);
    assign o_in_ready = !r_in_valid || w_advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_kind <= i_kind;
            r_rx   <= i_rx_byte;
            r_sw   <= i_switches;
            r_bt   <= i_buttons;
        end
    end

    srio_core #(
        .DEPTH (HISTORY_DEPTH)
    ) u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_fire       (w_advance),
        .i_kind       (r_kind),
        .i_rx_byte    (r_rx),
        .o_has_result (w_has_result),
        .o_res        (w_res)
    );

    srio_out u_out (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_load         (w_advance && w_has_result),
        .i_res          (w_res),
        .i_switches     (r_sw),
        .i_buttons      (r_bt),
        .i_out_ready    (i_out_ready),
        .o_free         (w_out_free),
        .o_out_valid    (o_out_valid),
        .o_result_kind  (o_result_kind),
        .o_led_value    (o_led_value),
        .o_seg_pattern  (o_seg_pattern),
        .o_digit_select (o_digit_select),
        .o_tx_byte      (o_tx_byte),
        .o_last         (o_last)
    );

    a_hold_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !w_advance) |=> (r_in_valid && $stable(r_kind) && $stable(r_rx)))
        else $error("pending item lost before it was processed");

endmodule

/* tb/sv/link_checker.sv */
// ----------------------------------------------------------------------------
// link_checker
// Watches both channels of the serial remote I/O link, keeps its own copy of
// the switch image, button history ring and scan position, predicts the
// result words of every accepted word and compares them in order.
// ----------------------------------------------------------------------------
module link_checker import srio_pkg::*; #(
    parameter int HISTORY_DEPTH = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  logic [1:0]  i_kind,
    input  logic [7:0]  i_rx_byte,
    input  logic [15:0] i_switches,
    input  logic [4:0]  i_buttons,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic [1:0]  i_result_kind,
    input  logic [15:0] i_led_value,
    input  logic [7:0]  i_seg_pattern,
    input  logic [7:0]  i_digit_select,
    input  logic [7:0]  i_tx_byte,
    input  logic        i_last,
    output int          o_fail_count,
    output int          o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] led;
        logic [7:0]  seg;
        logic [7:0]  sel;
        logic [7:0]  tx;
        logic        last;
    } t_link_word;

    t_link_word  expected_words[$];
    logic [15:0] image;
    logic [4:0]  prev_btn;
    logic [2:0]  history [HISTORY_DEPTH];
    logic [2:0]  wr_ptr;
    logic [2:0]  scan_ptr;
    int          mismatches = 0;
    int          word_count = 0;

    task automatic push_word(input logic [1:0] kind, input logic [7:0] seg,
                             input logic [7:0] sel, input logic [7:0] tx,
                             input logic last);
        t_link_word w;
        w.kind = kind;
        w.led  = image;
        w.seg  = seg;
        w.sel  = sel;
        w.tx   = tx;
        w.last = last;
        expected_words.push_back(w);
    endtask

    task automatic predict_link(input logic [1:0] kind, input logic [7:0] rx,
                                input logic [15:0] sw, input logic [4:0] bt);
        logic [4:0] btn;
        logic [2:0] entry;
        logic [7:0] seg;
        btn   = rx[6:2];
        entry = BLANK_ENTRY;
        case (kind)
            KIND_RX: begin
                case (rx[1:0])
                    TAG_LO:  image[5:0]   = rx[7:2];
                    TAG_MID: image[10:6]  = rx[6:2];
                    TAG_HI:  image[15:11] = rx[6:2];
                    default: begin
                        if (btn != prev_btn) begin
                            prev_btn = btn;
                            if ($onehot(btn)) begin
                                for (int b = 0; b < 5; b++)
                                    if (btn[b]) entry = 3'(b);
                                history[wr_ptr] = entry;
                                wr_ptr = 3'((int'(wr_ptr) + 1) % HISTORY_DEPTH);
                            end
                        end
                    end
                endcase
                if (rx[1:0] != TAG_BTN)
                    push_word(RES_LED, 8'h00, 8'h00, 8'h00, 1'b1);
            end
            KIND_SCAN: begin
                entry = history[(int'(wr_ptr) + int'(scan_ptr)) % HISTORY_DEPTH];
                case (entry)
                    3'd0:    seg = 8'hc6;
                    3'd1:    seg = 8'hc1;
                    3'd2:    seg = 8'hc7;
                    3'd3:    seg = 8'h88;
                    3'd4:    seg = 8'ha1;
                    default: seg = SEG_BLANK;
                endcase
                push_word(RES_DIGIT, seg, ~(SEL_FIRST >> scan_ptr), 8'h00, 1'b1);
                scan_ptr = scan_ptr + 3'd1;
            end
            KIND_SEND: begin
                push_word(RES_TX, 8'h00, 8'h00, {sw[5:0], TAG_LO}, 1'b0);
                push_word(RES_TX, 8'h00, 8'h00, {1'b0, sw[10:6], TAG_MID}, 1'b0);
                push_word(RES_TX, 8'h00, 8'h00, {1'b0, sw[15:11], TAG_HI}, 1'b0);
                push_word(RES_TX, 8'h00, 8'h00, {1'b0, bt, TAG_BTN}, 1'b1);
            end
            default: ;
        endcase
    endtask

    task automatic check_word();
        t_link_word got;
        t_link_word want;
        got = {i_result_kind, i_led_value, i_seg_pattern, i_digit_select,
               i_tx_byte, i_last};
        word_count++;
        if (expected_words.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) begin
                $display("[%0t] word %0d with nothing pending", $realtime, word_count);
                $display("    actual   kind=%0d led=%h seg=%h sel=%h tx=%h last=%b",
                         got.kind, got.led, got.seg, got.sel, got.tx, got.last);
            end
        end else begin
            want = expected_words.pop_front();
            if (got != want) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("[%0t] word %0d mismatch", $realtime, word_count);
                    $display("    expected kind=%0d led=%h seg=%h sel=%h tx=%h last=%b",
                             want.kind, want.led, want.seg, want.sel, want.tx, want.last);
                    $display("    actual   kind=%0d led=%h seg=%h sel=%h tx=%h last=%b",
                             got.kind, got.led, got.seg, got.sel, got.tx, got.last);
                end
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            image    = '0;
            prev_btn = '0;
            wr_ptr   = '0;
            scan_ptr = '0;
            for (int j = 0; j < HISTORY_DEPTH; j++)
                history[j] = BLANK_ENTRY;
            expected_words.delete();
        end else begin
            if (i_in_valid && i_in_ready)
                predict_link(i_kind, i_rx_byte, i_switches, i_buttons);
            if (i_out_valid && i_out_ready)
                check_word();
        end
        o_pending    <= expected_words.size();
        o_fail_count <= mismatches;
    end

endmodule

/* tb/sv/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Drives received bytes, scan ticks and send requests into the serial remote
// I/O link with random idle bursts on both channels, and reports the verdict
// of the link checker.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import srio_pkg::*;

    localparam int         HISTORY_DEPTH  = 8;
    localparam int         RANDOM_WORDS   = 480;
    localparam int         CALM_TAIL      = 60;
    localparam int         WATCHDOG_LIMIT = 2000;
    localparam logic [1:0] KIND_NONE      = 2'd3;

    logic        clk;
    logic        rst_n    = 1'b0;
    logic        in_valid = 1'b0;
    logic [1:0]  in_kind  = KIND_RX;
    logic [7:0]  rx_byte  = '0;
    logic [15:0] switches = '0;
    logic [4:0]  buttons  = '0;
    logic        out_ready = 1'b0;
    logic        o_in_ready;
    logic        o_out_valid;
    logic [1:0]  o_result_kind;
    logic [15:0] o_led_value;
    logic [7:0]  o_seg_pattern;
    logic [7:0]  o_digit_select;
    logic [7:0]  o_tx_byte;
    logic        o_last;
    int          fail_count;
    int          pending;

    int in_gap_pct  = 0;
    int out_gap_pct = 0;
    int stall_left  = 0;
    int quiet_cycles = 0;
    int results_seen = 0;
    int n_rx = 0, n_btn = 0, n_scan = 0, n_send = 0, n_none = 0;

    serial_remote_io_link #(.HISTORY_DEPTH(HISTORY_DEPTH)) DUT (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_in_valid     (in_valid),
        .o_in_ready     (o_in_ready),
        .i_kind         (in_kind),
        .i_rx_byte      (rx_byte),
        .i_switches     (switches),
        .i_buttons      (buttons),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (out_ready),
        .o_result_kind  (o_result_kind),
        .o_led_value    (o_led_value),
        .o_seg_pattern  (o_seg_pattern),
        .o_digit_select (o_digit_select),
        .o_tx_byte      (o_tx_byte),
        .o_last         (o_last)
    );

    link_checker #(.HISTORY_DEPTH(HISTORY_DEPTH)) u_checker (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_in_valid     (in_valid),
        .i_in_ready     (o_in_ready),
        .i_kind         (in_kind),
        .i_rx_byte      (rx_byte),
        .i_switches     (switches),
        .i_buttons      (buttons),
        .i_out_valid    (o_out_valid),
        .i_out_ready    (out_ready),
        .i_result_kind  (o_result_kind),
        .i_led_value    (o_led_value),
        .i_seg_pattern  (o_seg_pattern),
        .i_digit_select (o_digit_select),
        .i_tx_byte      (o_tx_byte),
        .i_last         (o_last),
        .o_fail_count   (fail_count),
        .o_pending      (pending)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // receiver stalls in random bursts
    always @(posedge clk) begin
        if (stall_left == 0 && $urandom_range(99) < out_gap_pct)
            stall_left = $urandom_range(13, 1);
        if (stall_left > 0) begin
            out_ready <= 1'b0;
            stall_left--;
        end else begin
            out_ready <= 1'b1;
        end
    end

    always @(posedge clk) begin
        if (o_out_valid && out_ready)
            results_seen++;
        if ((in_valid && o_in_ready) || (o_out_valid && out_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no handshake for %0d cycles, %0d words pending",
                     quiet_cycles, pending);
            $display("end of test: mismatches");
            $finish;
        end
    end

    task automatic send_word(input logic [1:0] k, input logic [7:0] rx,
                             input logic [15:0] sw, input logic [4:0] bt);
        in_valid <= 1'b1;
        in_kind  <= k;
        rx_byte  <= rx;
        switches <= sw;
        buttons  <= bt;
        do @(posedge clk); while (!o_in_ready);
        case (k)
            KIND_RX:   if (rx[1:0] == TAG_BTN) n_btn++; else n_rx++;
            KIND_SCAN: n_scan++;
            KIND_SEND: n_send++;
            default:   n_none++;
        endcase
        if ($urandom_range(99) < in_gap_pct) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(13, 1)) @(posedge clk);
        end
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
    endtask

    function automatic logic [7:0] button_byte(input logic [4:0] btn);
        return {1'($urandom_range(1)), btn, TAG_BTN};
    endfunction

    initial begin
        logic [1:0]  k;
        logic [7:0]  rx;
        logic [4:0]  btn;
        int          pick;
        int          counted;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // image slices at both extremes, top bit of payload set
        send_word(KIND_RX, {6'h3f, TAG_LO}, 16'h0000, 5'h00);
        send_word(KIND_RX, 8'hfd, 16'h0000, 5'h00);
        send_word(KIND_RX, 8'hfe, 16'h0000, 5'h00);
        send_word(KIND_RX, {6'h00, TAG_LO}, 16'hffff, 5'h1f);
        send_word(KIND_RX, {6'h00, TAG_MID}, 16'hffff, 5'h1f);
        send_word(KIND_RX, {6'h20, TAG_HI}, 16'h0000, 5'h00);
        // buttons: new, repeated, zero, not one-hot, repeat with bit 7 set
        send_word(KIND_RX, {1'b0, 5'b00001, TAG_BTN}, 16'h0000, 5'h00);
        send_word(KIND_RX, {1'b0, 5'b00001, TAG_BTN}, 16'h0000, 5'h00);
        send_word(KIND_RX, {1'b0, 5'b00000, TAG_BTN}, 16'h0000, 5'h00);
        send_word(KIND_RX, {1'b0, 5'b00011, TAG_BTN}, 16'h0000, 5'h00);
        send_word(KIND_RX, {1'b0, 5'b10000, TAG_BTN}, 16'h0000, 5'h00);
        send_word(KIND_RX, {1'b1, 5'b10000, TAG_BTN}, 16'h0000, 5'h00);
        send_word(KIND_RX, {1'b1, 5'b00010, TAG_BTN}, 16'h0000, 5'h00);
        send_word(KIND_RX, {1'b0, 5'b00100, TAG_BTN}, 16'h0000, 5'h00);
        send_word(KIND_RX, {1'b0, 5'b01000, TAG_BTN}, 16'h0000, 5'h00);
        // full scan round, blanks and wrap of the digit select
        for (int s = 0; s < 8; s++)
            send_word(KIND_SCAN, 8'hff, 16'hffff, 5'h1f);
        send_word(KIND_SEND, 8'h00, 16'hffff, 5'h1f);
        send_word(KIND_SEND, 8'hff, 16'h0000, 5'h00);
        send_word(KIND_NONE, 8'hff, 16'hffff, 5'h1f);
        drain_results();

        counted = 0;
        while (counted < RANDOM_WORDS) begin
            if (counted % 60 == 0) begin
                if (counted >= RANDOM_WORDS - CALM_TAIL) begin
                    in_gap_pct  = 0;
                    out_gap_pct = 0;
                end else begin
                    in_gap_pct  = 10 * $urandom_range(4);
                    out_gap_pct = 10 * $urandom_range(4);
                end
                if (counted % 120 == 60)
                    drain_results();
            end
            pick = $urandom_range(99);
            if (pick < 50) begin
                k = KIND_RX;
                rx = 8'($urandom);
                if (rx[1:0] == TAG_BTN) begin
                    if ($urandom_range(99) < 65)
                        btn = 5'b00001 << $urandom_range(4);
                    else
                        btn = 5'($urandom_range(31));
                    rx = button_byte(btn);
                end
            end else if (pick < 75) begin
                k  = KIND_SCAN;
                rx = 8'($urandom);
            end else if (pick < 95) begin
                k  = KIND_SEND;
                rx = 8'($urandom);
            end else begin
                k  = KIND_NONE;
                rx = 8'($urandom);
            end
            send_word(k, rx, 16'($urandom), 5'($urandom));
            if (k != KIND_NONE)
                counted++;
        end

        drain_results();
        repeat (8) @(posedge clk);
        $display("covered %0d image bytes, %0d button bytes, %0d scan ticks, %0d send requests",
                 n_rx, n_btn, n_scan, n_send);
        $display("plus %0d unused kinds; %0d result words checked", n_none, results_seen);
        if (fail_count == 0 && pending == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

/* serial_remote_io_link.f */
hw/rtl/srio_pkg.sv
hw/rtl/srio_core.sv
hw/rtl/srio_out.sv
hw/rtl/serial_remote_io_link.sv
tb/sv/link_checker.sv
tb/sv/tb.sv
